[hw/rtl/sitra_pkg.sv]
// Shared constants, a status type and a helper function for the radix ASCII converter.
`timescale 1ns / 1ps

package sitra_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RADIX_W         = 5;
	localparam int DIGIT_W         = 4;
	localparam int CHAR_W          = 8;
	localparam int DIV_STEP_BITS   = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'd45;
	localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd55;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

	// Status handed from the divider to the sequencer.
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} div_stat_t;

	// Digit value to its ASCII character: 0-9 as digits, 10-15 as uppercase letters.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d >= DIGIT_TEN) begin
			return ext + LETTER_OFFSET;
		end
		return ext + CHAR_ZERO;
	endfunction

endpackage

[hw/rtl/sitra_div_unit.sv]
// Iterative divider by a small radix, a few quotient bits per cycle.
`timescale 1ns / 1ps

module sitra_div_unit #(
	parameter int VALUE_WIDTH = sitra_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [VALUE_WIDTH-1:0]            dividend,
	input  logic [sitra_pkg::RADIX_W-1:0]     radix,
	output sitra_pkg::div_stat_t              stat,
	output logic [VALUE_WIDTH-1:0]            quotient
);

	localparam int STEP     = sitra_pkg::DIV_STEP_BITS;
	localparam int ITERS    = (VALUE_WIDTH + STEP - 1) / STEP;
	localparam int PAD_W    = ITERS * STEP;
	localparam int CNT_W    = (ITERS > 1) ? $clog2(ITERS) : 1;
	localparam int DW       = sitra_pkg::DIGIT_W;
	localparam int RW       = sitra_pkg::RADIX_W;

	logic [PAD_W-1:0] sh_q;
	logic [DW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [PAD_W-1:0] sh_next;
	logic [DW-1:0]    rem_next;

	// Restoring division over the top STEP bits of the shift register;
	// quotient bits are shifted in at the bottom as dividend bits leave the top.
	always_comb begin
		logic [RW-1:0]   r;
		logic [DW-1:0]   cur;
		logic [STEP-1:0] qbits;
		cur   = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP; i++) begin
			r = {cur, sh_q[PAD_W-1-i]};
			if (r >= radix) begin
				r = r - radix;
				qbits[STEP-1-i] = 1'b1;
			end
			cur = r[DW-1:0];
		end
		rem_next = cur;
		sh_next  = {sh_q[PAD_W-STEP-1:0], qbits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ITERS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= {{(PAD_W-VALUE_WIDTH){1'b0}}, dividend};
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_next;
			rem_q <= rem_next;
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;
	assign quotient  = sh_q[VALUE_WIDTH-1:0];

endmodule

[hw/rtl/sitra_digit_buf.sv]
// Digit store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sitra_digit_buf #(
	parameter int DEPTH = sitra_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  logic [sitra_pkg::DIGIT_W-1:0]  wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	output logic [sitra_pkg::DIGIT_W-1:0]  rd_data
);

	logic [sitra_pkg::DIGIT_W-1:0] mem [DEPTH];
	logic [sitra_pkg::DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/signed_int_to_radix_ascii_core.sv]
// Top level: signed integer to ASCII digits in a chosen radix, streamed one character per item.
`timescale 1ns / 1ps
// Division: each digit is the remainder of one division by the shared divider, which resolves
// four quotient bits per cycle; emission then passes each character through the issue and load
// states via the digit store's registered read port, after a minus sign where one is shown.
// Throughput: one input item at a time.
// Reset: arst_n clears the sequencer, divider control and output valid at once.

module signed_int_to_radix_ascii_core #(
	parameter int VALUE_WIDTH = sitra_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input items.
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// s_tdata fields from bit 0: value (VALUE_WIDTH, signed), radix (5), zero fill.
	input  logic [((VALUE_WIDTH+sitra_pkg::RADIX_W+7)/8)*8-1:0] s_tdata,
	// Result items.
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// m_tdata fields from bit 0: ascii_char (8).
	output logic [sitra_pkg::CHAR_W-1:0]           m_tdata,
	// m_tlast: last_char, high on the final character of a number.
	output logic                                   m_tlast
);

	localparam int AW = $clog2(VALUE_WIDTH);
	localparam int RW = sitra_pkg::RADIX_W;
	localparam int CW = sitra_pkg::CHAR_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_ISSUE,
		ST_LOAD
	} state_t;

	state_t              state_q;
	logic [RW-1:0]       radix_q;
	logic                neg_dec_q;
	logic [AW-1:0]       nd_q;
	logic [AW-1:0]       ptr_q;
	logic                out_valid_q;
	logic [CW-1:0]       out_char_q;
	logic                out_last_q;

	logic [VALUE_WIDTH-1:0]       in_value;
	logic [RW-1:0]                in_radix;
	logic [RW-1:0]                radix_clamped;
	logic                         in_neg;
	logic [VALUE_WIDTH-1:0]       in_mag;
	logic                         accept;
	logic                         out_free;
	logic                         out_load;

	sitra_pkg::div_stat_t         div_stat;
	logic [VALUE_WIDTH-1:0]       div_quot;
	logic                         div_start;
	logic [VALUE_WIDTH-1:0]       div_dividend;
	logic [RW-1:0]                div_radix;
	logic                         quot_zero;
	logic                         digit_wr;
	logic                         rd_en;
	logic [sitra_pkg::DIGIT_W-1:0] rd_digit;

	assign in_value = s_tdata[VALUE_WIDTH-1:0];
	assign in_radix = s_tdata[VALUE_WIDTH+RW-1:VALUE_WIDTH];
	assign in_neg   = in_value[VALUE_WIDTH-1];
	// The magnitude is taken as unsigned, so the most negative value converts correctly.
	assign in_mag   = in_neg ? (VALUE_WIDTH'(0) - in_value) : in_value;

	// Radices below two act as two, those above sixteen as sixteen.
	always_comb begin
		radix_clamped = in_radix;
		if (in_radix < sitra_pkg::RADIX_MIN) begin
			radix_clamped = sitra_pkg::RADIX_MIN;
		end else if (in_radix > sitra_pkg::RADIX_MAX) begin
			radix_clamped = sitra_pkg::RADIX_MAX;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	// A new character enters the output register from the sign or the load state.
	assign out_load = ((state_q == ST_SIGN) || (state_q == ST_LOAD)) && out_free;

	// Each digit is the remainder of one division; the quotient feeds the next one.
	// A zero magnitude still runs one division and so yields the single digit zero.
	assign quot_zero    = (div_quot == '0);
	assign digit_wr     = (state_q == ST_DIV) && div_stat.done;
	assign div_start    = accept || (digit_wr && !quot_zero);
	assign div_dividend = (state_q == ST_IDLE) ? in_mag : div_quot;
	assign div_radix    = (state_q == ST_IDLE) ? radix_clamped : radix_q;
	assign rd_en        = (state_q == ST_ISSUE);

	sitra_div_unit #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (div_radix),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Digits are stored least significant first and read back in reverse.
	sitra_digit_buf #(
		.DEPTH (VALUE_WIDTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (digit_wr),
		.wr_addr (nd_q),
		.wr_data (div_stat.rem),
		.rd_en   (rd_en),
		.rd_addr (ptr_q),
		.rd_data (rd_digit)
	);

	// Sequencer and output register. A finished character may wait in the output
	// register while the next item is already being divided.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= sitra_pkg::RADIX_MIN;
			neg_dec_q   <= 1'b0;
			nd_q        <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						radix_q   <= radix_clamped;
						// Only base ten shows a sign; other bases print the magnitude.
						neg_dec_q <= in_neg && (radix_clamped == sitra_pkg::RADIX_DEC);
						nd_q      <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						nd_q <= nd_q + 1'b1;
						if (quot_zero) begin
							ptr_q   <= nd_q;
							state_q <= neg_dec_q ? ST_SIGN : ST_ISSUE;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_char_q  <= sitra_pkg::CHAR_MINUS;
						out_last_q  <= 1'b0;
						state_q     <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_char_q  <= sitra_pkg::digit_char(rd_digit);
						out_last_q  <= (ptr_q == '0);
						if (ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

endmodule
